/* rtl/cab_pkg.sv */
// ----------------------------------------------------------------------------
// cab_pkg: shared types and constants for the circle and box collision test
// Holds the datapath widths, the side codes and the stage structs that pass
// between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cab_pkg;

  // Signed width of the doubled (Q11.5) centre offsets and nearest-point vectors.
  localparam int DiffW = 21;
  // Width of a magnitude of such a vector.
  localparam int MagW  = DiffW - 1;
  // Width of a squared magnitude and of the sum of two of them.
  localparam int SqW   = 2 * MagW;
  localparam int SumW  = SqW + 1;

  typedef enum logic [2:0] {
    SIDE_NEG_Y = 3'd0,
    SIDE_POS_Y = 3'd1,
    SIDE_NEG_X = 3'd2,
    SIDE_POS_X = 3'd3,
    SIDE_NONE  = 3'd4
  } side_t;

  // Output of the geometry stage.
  typedef struct packed {
    logic                    mode;
    logic                    box_hit;
    logic [15:0]             r2;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
  } geom_t;

  // Output of the distance stage.
  typedef struct packed {
    logic            mode;
    logic            box_hit;
    logic [15:0]     r2;
    logic [MagW-1:0] abs_dx;
    logic [MagW-1:0] abs_dy;
    logic [SqW-1:0]  sq_x;
    logic [SqW-1:0]  sq_y;
    logic [31:0]     rr;
    side_t           side;
  } dist_t;

endpackage

`default_nettype wire

/* rtl/cab_geom.sv */
// ----------------------------------------------------------------------------
// cab_geom: geometry stage
// Box overlap test, and the clamped vector from the circle centre to the
// nearest box point, all in doubled units. One registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cab_geom (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               mode,
  input  wire logic signed [15:0] first_x,
  input  wire logic signed [15:0] first_y,
  input  wire logic        [14:0] first_w,
  input  wire logic        [14:0] first_h,
  input  wire logic        [14:0] radius,
  input  wire logic signed [15:0] second_x,
  input  wire logic signed [15:0] second_y,
  input  wire logic        [14:0] second_w,
  input  wire logic        [14:0] second_h,
  output logic                    out_valid,
  output cab_pkg::geom_t          out_geom
);

  localparam int DW = cab_pkg::DiffW;

  logic signed [17:0]   fx_e, fy_e, sx_e, sy_e;
  logic signed [17:0]   f_right, f_bottom, s_right, s_bottom;
  logic                 box_hit;
  logic signed [DW-1:0] ccx, ccy, bcx, bcy;
  logic signed [DW-1:0] diff_x, diff_y, ext_x, ext_y, clamp_x, clamp_y;
  cab_pkg::geom_t       geom_next;

  always_comb begin
    fx_e     = {{2{first_x[15]}}, first_x};
    fy_e     = {{2{first_y[15]}}, first_y};
    sx_e     = {{2{second_x[15]}}, second_x};
    sy_e     = {{2{second_y[15]}}, second_y};
    f_right  = fx_e + {3'b000, first_w};
    f_bottom = fy_e + {3'b000, first_h};
    s_right  = sx_e + {3'b000, second_w};
    s_bottom = sy_e + {3'b000, second_h};
    box_hit  = (f_right >= sx_e) && (s_right >= fx_e) &&
               (f_bottom >= sy_e) && (s_bottom >= fy_e);

    // Circle centre is the corner plus the radius; box centre is the corner
    // plus half the extent. Doubling both keeps the halving exact.
    ccx = ({{(DW-16){first_x[15]}}, first_x} + {{(DW-15){1'b0}}, radius}) <<< 1;
    ccy = ({{(DW-16){first_y[15]}}, first_y} + {{(DW-15){1'b0}}, radius}) <<< 1;
    bcx = ({{(DW-16){second_x[15]}}, second_x} <<< 1) + {{(DW-15){1'b0}}, second_w};
    bcy = ({{(DW-16){second_y[15]}}, second_y} <<< 1) + {{(DW-15){1'b0}}, second_h};

    diff_x = ccx - bcx;
    diff_y = ccy - bcy;
    ext_x  = {{(DW-15){1'b0}}, second_w};
    ext_y  = {{(DW-15){1'b0}}, second_h};

    if (diff_x < -ext_x) begin
      clamp_x = -ext_x;
    end else if (diff_x > ext_x) begin
      clamp_x = ext_x;
    end else begin
      clamp_x = diff_x;
    end
    if (diff_y < -ext_y) begin
      clamp_y = -ext_y;
    end else if (diff_y > ext_y) begin
      clamp_y = ext_y;
    end else begin
      clamp_y = diff_y;
    end

    // Nearest point minus circle centre reduces to clamp minus offset.
    geom_next.mode    = mode;
    geom_next.box_hit = box_hit;
    geom_next.r2      = {radius, 1'b0};
    geom_next.dx      = clamp_x - diff_x;
    geom_next.dy      = clamp_y - diff_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_geom <= geom_next;
  end

endmodule

`default_nettype wire

/* rtl/cab_dist.sv */
// ----------------------------------------------------------------------------
// cab_dist: distance stage
// Squares the nearest-point vector and the doubled radius, and picks the
// contact side from the vector. One registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cab_dist (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  cab_pkg::geom_t      in_geom,
  output logic                out_valid,
  output cab_pkg::dist_t      out_dist
);

  localparam int DW = cab_pkg::DiffW;
  localparam int MW = cab_pkg::MagW;

  logic signed [DW-1:0] neg_dx, neg_dy;
  logic [MW-1:0]        abs_dx, abs_dy;
  cab_pkg::side_t       side;
  cab_pkg::dist_t       dist_next;

  always_comb begin
    neg_dx = -in_geom.dx;
    neg_dy = -in_geom.dy;
    abs_dx = in_geom.dx[DW-1] ? neg_dx[MW-1:0] : in_geom.dx[MW-1:0];
    abs_dy = in_geom.dy[DW-1] ? neg_dy[MW-1:0] : in_geom.dy[MW-1:0];

    // The y candidates come first, so y wins a tie in magnitude.
    if (abs_dx == '0 && abs_dy == '0) begin
      side = cab_pkg::SIDE_NONE;
    end else if (abs_dy != '0 && abs_dy >= abs_dx) begin
      side = in_geom.dy[DW-1] ? cab_pkg::SIDE_NEG_Y : cab_pkg::SIDE_POS_Y;
    end else begin
      side = in_geom.dx[DW-1] ? cab_pkg::SIDE_NEG_X : cab_pkg::SIDE_POS_X;
    end

    dist_next.mode    = in_geom.mode;
    dist_next.box_hit = in_geom.box_hit;
    dist_next.r2      = in_geom.r2;
    dist_next.abs_dx  = abs_dx;
    dist_next.abs_dy  = abs_dy;
    dist_next.sq_x    = abs_dx * abs_dx;
    dist_next.sq_y    = abs_dy * abs_dy;
    dist_next.rr      = in_geom.r2 * in_geom.r2;
    dist_next.side    = side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_dist <= dist_next;
  end

endmodule

`default_nettype wire

/* rtl/circle_and_box_collision_test.sv */
// ----------------------------------------------------------------------------
// circle_and_box_collision_test: pipelined 2D collision test
// Box against box overlap, or circle against box with penetration depths and
// a contact side, in signed Q12.4 input and Q11.5 output units.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with the shape fields; busy is always low, so a
//   beat is taken at every rising edge where start is high. A new test can
//   enter in every cycle; the block holds no state between tests.
//   Result beat: done is high for exactly one cycle with hit, depth_x,
//   depth_y and side valid in that cycle. Every input beat yields exactly one
//   result beat, in input order.
//   Path: a beat passes the input, geometry, distance and result registers
//   in that order, and done is the valid bit of the result register.
//   Throughput is one test per cycle, set by the four register stages
//   (input, geometry, distance, result) each taking a new item every clock.
//   The receiver cannot stall; results are not held, so it must take each
//   beat in the cycle it appears.
//   Reset: rst clears the valid bits of all stages, so no result beat
//   appears after reset until a new input beat arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_and_box_collision_test (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic signed [15:0] first_x,
  input  wire logic signed [15:0] first_y,
  input  wire logic        [14:0] first_w,
  input  wire logic        [14:0] first_h,
  input  wire logic        [14:0] radius,
  input  wire logic signed [15:0] second_x,
  input  wire logic signed [15:0] second_y,
  input  wire logic        [14:0] second_w,
  input  wire logic        [14:0] second_h,
  output logic                    done,
  output logic                    hit,
  output logic             [15:0] depth_x,
  output logic             [15:0] depth_y,
  output logic             [2:0]  side
);

  localparam int SW = cab_pkg::SumW;

  // Input register.
  logic               in_valid;
  logic               mode_q;
  logic signed [15:0] first_x_q, first_y_q, second_x_q, second_y_q;
  logic        [14:0] first_w_q, first_h_q, radius_q, second_w_q, second_h_q;

  logic           geom_valid, dist_valid;
  cab_pkg::geom_t geom;
  cab_pkg::dist_t dist_data;

  logic [SW-1:0] d2;
  logic [SW-1:0] rr_e;
  logic          inner, touch;
  logic          hit_next;
  logic [15:0]   depth_x_next, depth_y_next;
  logic [2:0]    side_next;

  // The pipeline never stalls, so the block is always ready.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mode_q     <= mode;
    first_x_q  <= first_x;
    first_y_q  <= first_y;
    first_w_q  <= first_w;
    first_h_q  <= first_h;
    radius_q   <= radius;
    second_x_q <= second_x;
    second_y_q <= second_y;
    second_w_q <= second_w;
    second_h_q <= second_h;
  end

  cab_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode_q),
    .first_x   (first_x_q),
    .first_y   (first_y_q),
    .first_w   (first_w_q),
    .first_h   (first_h_q),
    .radius    (radius_q),
    .second_x  (second_x_q),
    .second_y  (second_y_q),
    .second_w  (second_w_q),
    .second_h  (second_h_q),
    .out_valid (geom_valid),
    .out_geom  (geom)
  );

  cab_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (geom_valid),
    .in_geom   (geom),
    .out_valid (dist_valid),
    .out_dist  (dist_data)
  );

  // Final stage: compare the squared distance against the squared radius.
  // A distance strictly inside the radius gives penetration; equality is a touch only.
  // When the distance is strictly inside, each magnitude is below the doubled
  // radius, so a 16-bit difference is exact.
  always_comb begin
    d2    = {1'b0, dist_data.sq_x} + {1'b0, dist_data.sq_y};
    rr_e  = {{(SW-32){1'b0}}, dist_data.rr};
    inner = d2 < rr_e;
    touch = d2 <= rr_e;

    if (dist_data.mode) begin
      hit_next  = touch;
      side_next = dist_data.side;
      if (inner) begin
        depth_x_next = dist_data.r2 - dist_data.abs_dx[15:0];
        depth_y_next = dist_data.r2 - dist_data.abs_dy[15:0];
      end else begin
        depth_x_next = '0;
        depth_y_next = '0;
      end
    end else begin
      hit_next     = dist_data.box_hit;
      side_next    = cab_pkg::SIDE_NONE;
      depth_x_next = '0;
      depth_y_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit     <= hit_next;
    depth_x <= depth_x_next;
    depth_y <= depth_y_next;
    side    <= side_next;
  end

  // Each accepted beat comes out as a result beat with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done)
    else $error("result beat missing four cycles after an input beat");

  // Penetration is reported only for a hit.
  a_depth_needs_hit: assert property (@(posedge clk) disable iff (rst)
    done && (depth_x != 16'd0 || depth_y != 16'd0) |-> hit)
    else $error("nonzero depth without a hit");

  // A box test reports neither depth nor side.
  a_box_result: assert property (@(posedge clk) disable iff (rst)
    dist_valid && !dist_data.mode |=> depth_x == 16'd0 && depth_y == 16'd0 &&
      side == cab_pkg::SIDE_NONE)
    else $error("box test produced depth or side");

  // In a circle test, a zero nearest-point vector gives no side and a hit.
  a_side_none: assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_data.mode && dist_data.abs_dx == '0 && dist_data.abs_dy == '0
      |=> side == cab_pkg::SIDE_NONE && hit)
    else $error("centre inside box must give no side and a hit");

endmodule

`default_nettype wire

/* verif/cab_contact_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cab_contact_checker: result checker for the circle and box collision test
// Predicts the contact result for every accepted test beat and compares each
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------

module cab_contact_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic               mode,
  input  wire logic signed [15:0] first_x,
  input  wire logic signed [15:0] first_y,
  input  wire logic        [14:0] first_w,
  input  wire logic        [14:0] first_h,
  input  wire logic        [14:0] radius,
  input  wire logic signed [15:0] second_x,
  input  wire logic signed [15:0] second_y,
  input  wire logic        [14:0] second_w,
  input  wire logic        [14:0] second_h,
  input  wire logic               done,
  input  wire logic               hit,
  input  wire logic        [15:0] depth_x,
  input  wire logic        [15:0] depth_y,
  input  wire logic        [2:0]  side,
  output int                      fail_count,
  output int                      pending
);

  typedef struct {
    logic            hit;
    logic [15:0]     depth_x;
    logic [15:0]     depth_y;
    cab_pkg::side_t  side;
  } contact_t;

  contact_t contacts_due[$];

  // All lengths are doubled before the circle test so that box half extents
  // stay integral.
  function automatic contact_t predict_contact(
    input logic               m,
    input logic signed [15:0] fx_i,
    input logic signed [15:0] fy_i,
    input logic        [14:0] fw_i,
    input logic        [14:0] fh_i,
    input logic        [14:0] r_i,
    input logic signed [15:0] sx_i,
    input logic signed [15:0] sy_i,
    input logic        [14:0] sw_i,
    input logic        [14:0] sh_i
  );
    longint   fx, fy, fw, fh, r, sx, sy, sw, sh;
    longint   r2, ccx, ccy, bcx, bcy, ox, oy, dx, dy, d2, rr, best;
    contact_t c;
    fx = fx_i;
    fy = fy_i;
    fw = fw_i;
    fh = fh_i;
    r  = r_i;
    sx = sx_i;
    sy = sy_i;
    sw = sw_i;
    sh = sh_i;
    c.hit     = 1'b0;
    c.depth_x = '0;
    c.depth_y = '0;
    c.side    = cab_pkg::SIDE_NONE;
    if (!m) begin
      c.hit = (fx + fw >= sx) && (sx + sw >= fx) && (fy + fh >= sy) && (sy + sh >= fy);
    end else begin
      r2  = 2 * r;
      ccx = 2 * (fx + r);
      ccy = 2 * (fy + r);
      bcx = 2 * sx + sw;
      bcy = 2 * sy + sh;
      ox  = ccx - bcx;
      oy  = ccy - bcy;
      if (ox < -sw) ox = -sw;
      else if (ox > sw) ox = sw;
      if (oy < -sh) oy = -sh;
      else if (oy > sh) oy = sh;
      dx = bcx + ox - ccx;
      dy = bcy + oy - ccy;
      d2 = dx * dx + dy * dy;
      rr = r2 * r2;
      c.hit = (d2 <= rr);
      if (d2 < rr) begin
        c.depth_x = 16'(r2 - ((dx < 0) ? -dx : dx));
        c.depth_y = 16'(r2 - ((dy < 0) ? -dy : dy));
      end
      // First strictly largest positive component wins; ties keep the earlier.
      best = 0;
      if (-dy > best) begin best = -dy; c.side = cab_pkg::SIDE_NEG_Y; end
      if (dy > best) begin best = dy; c.side = cab_pkg::SIDE_POS_Y; end
      if (-dx > best) begin best = -dx; c.side = cab_pkg::SIDE_NEG_X; end
      if (dx > best) begin best = dx; c.side = cab_pkg::SIDE_POS_X; end
    end
    return c;
  endfunction

  always @(posedge clk) begin
    contact_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (contacts_due.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: result beat with nothing expected: hit=%0d dx=%0d dy=%0d side=%0d",
                   $time, hit, depth_x, depth_y, side);
        end else begin
          want = contacts_due.pop_front();
          if (hit !== want.hit || depth_x !== want.depth_x || depth_y !== want.depth_y ||
              side !== want.side) begin
            fail_count = fail_count + 1;
            $display("%0t: mismatch: expected hit=%0d dx=%0d dy=%0d side=%0d, actual hit=%0d dx=%0d dy=%0d side=%0d",
                     $time, want.hit, want.depth_x, want.depth_y, want.side,
                     hit, depth_x, depth_y, side);
          end
        end
      end
      if (start && !busy) begin
        contacts_due.push_back(predict_contact(mode, first_x, first_y, first_w, first_h,
                                               radius, second_x, second_y, second_w,
                                               second_h));
      end
    end
    pending <= contacts_due.size();
  end

endmodule

/* verif/tb_circle_and_box_collision_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_and_box_collision_test: testbench for the collision test block
// Drives directed and random test beats with random gaps and bursts into the
// block, while a checker beside it predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_circle_and_box_collision_test;

  // Generous cycle budget for about 420 beats with random gaps, so this only
  // trips on a hang.
  localparam int CycleLimit = 200000;

  typedef struct {
    logic               mode;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic        [14:0] fw;
    logic        [14:0] fh;
    logic        [14:0] r;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic        [14:0] sw;
    logic        [14:0] sh;
  } collision_test_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  logic               mode     = 1'b0;
  logic signed [15:0] first_x  = '0;
  logic signed [15:0] first_y  = '0;
  logic        [14:0] first_w  = '0;
  logic        [14:0] first_h  = '0;
  logic        [14:0] radius   = '0;
  logic signed [15:0] second_x = '0;
  logic signed [15:0] second_y = '0;
  logic        [14:0] second_w = '0;
  logic        [14:0] second_h = '0;
  logic               busy;
  logic               done;
  logic               hit;
  logic        [15:0] depth_x;
  logic        [15:0] depth_y;
  logic        [2:0]  side;
  int                 fail_count;
  int                 pending;
  int                 cycles   = 0;

  always #5 clk = ~clk;

  circle_and_box_collision_test u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .first_x  (first_x),
    .first_y  (first_y),
    .first_w  (first_w),
    .first_h  (first_h),
    .radius   (radius),
    .second_x (second_x),
    .second_y (second_y),
    .second_w (second_w),
    .second_h (second_h),
    .done     (done),
    .hit      (hit),
    .depth_x  (depth_x),
    .depth_y  (depth_y),
    .side     (side)
  );

  cab_contact_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .first_x    (first_x),
    .first_y    (first_y),
    .first_w    (first_w),
    .first_h    (first_h),
    .radius     (radius),
    .second_x   (second_x),
    .second_y   (second_y),
    .second_w   (second_w),
    .second_h   (second_h),
    .done       (done),
    .hit        (hit),
    .depth_x    (depth_x),
    .depth_y    (depth_y),
    .side       (side),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // A hung block or a lost result beat ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Plain integers are cut down to the port widths, so wrapped coordinates
  // simply land somewhere else in the plane.
  function automatic collision_test_t make_test(
    input int m, input int fx, input int fy, input int fw, input int fh, input int r,
    input int sx, input int sy, input int sw, input int sh
  );
    collision_test_t t;
    t.mode = m[0];
    t.fx   = fx[15:0];
    t.fy   = fy[15:0];
    t.fw   = fw[14:0];
    t.fh   = fh[14:0];
    t.r    = r[14:0];
    t.sx   = sx[15:0];
    t.sy   = sy[15:0];
    t.sw   = sw[14:0];
    t.sh   = sh[14:0];
    return t;
  endfunction

  // Most random tests place the two shapes close together so that hits,
  // penetration and every contact side show up often. Fully random beats
  // make up the rest and toggle every field bit.
  function automatic collision_test_t random_test();
    int kind, m, sx, sy, sw, sh, fx, fy, fw, fh, r, k;
    kind = $urandom_range(0, 9);
    m    = $urandom_range(0, 1);
    sx   = $urandom_range(0, 16000) - 8000;
    sy   = $urandom_range(0, 16000) - 8000;
    sw   = $urandom_range(0, 511);
    sh   = $urandom_range(0, 511);
    fw   = $urandom_range(0, 511);
    fh   = $urandom_range(0, 511);
    r    = $urandom_range(0, 511);
    fx   = sx + $urandom_range(0, 1600) - 800;
    fy   = sy + $urandom_range(0, 1600) - 800;
    case (kind)
      0, 1: begin
        m  = $urandom;
        fx = $urandom;
        fy = $urandom;
        fw = $urandom;
        fh = $urandom;
        r  = $urandom;
        sx = $urandom;
        sy = $urandom;
        sw = $urandom;
        sh = $urandom;
      end
      6: begin
        // Two boxes sharing exactly one edge on the x axis.
        m  = 0;
        fy = sy;
        if ($urandom_range(0, 1)) fx = sx + sw;
        else fx = sx - fw;
      end
      7: begin
        // A circle resting exactly on one face of the box.
        m = 1;
        case ($urandom_range(0, 3))
          0: begin fx = sx - 2 * r; fy = sy - r + $urandom_range(0, sh); end
          1: begin fx = sx + sw; fy = sy - r + $urandom_range(0, sh); end
          2: begin fy = sy - 2 * r; fx = sx - r + $urandom_range(0, sw); end
          default: begin fy = sy + sh; fx = sx - r + $urandom_range(0, sw); end
        endcase
      end
      8: begin
        // A circle touching the top-left corner along a 3-4-5 diagonal.
        m  = 1;
        k  = $urandom_range(1, 300);
        r  = 5 * k;
        fx = sx - 8 * k;
        fy = sy - 9 * k;
      end
      9: begin
        // A large circle whose centre tends to fall inside the box.
        m  = 1;
        r  = $urandom_range(0, 4000);
        fx = sx - r + $urandom_range(0, sw);
        fy = sy - r + $urandom_range(0, sh);
      end
      default: ;
    endcase
    return make_test(m, fx, fy, fw, fh, r, sx, sy, sw, sh);
  endfunction

  // Presents one test beat after a random gap, or straight away in a burst.
  // Called at a rising edge, it returns at the edge that takes the beat, so
  // start stays high across back-to-back beats without a glitch.
  task automatic send_test(input collision_test_t t, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    mode     <= t.mode;
    first_x  <= t.fx;
    first_y  <= t.fy;
    first_w  <= t.fw;
    first_h  <= t.fh;
    radius   <= t.r;
    second_x <= t.sx;
    second_y <= t.sy;
    second_w <= t.sw;
    second_h <= t.sh;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every predicted result beat has been seen.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    bit burst;
    burst = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Box against box: coincident zero-size boxes, edge contact on each axis,
    // one unit apart, and both corners of the coordinate range.
    send_test(make_test(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_test(make_test(0, 0, 0, 16, 16, 0, 16, 0, 16, 16), 1'b0);
    send_test(make_test(0, 0, 0, 16, 16, 0, 17, 0, 16, 16), 1'b0);
    send_test(make_test(0, 0, 0, 16, 16, 0, 0, 16, 16, 16), 1'b0);
    send_test(make_test(0, 0, 0, 16, 16, 0, 0, 17, 16, 16), 1'b0);
    send_test(make_test(0, -32768, -32768, 32767, 32767, 0, 32767, 32767, 32767, 32767),
              1'b0);
    send_test(make_test(0, 32767, 32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767),
              1'b0);
    send_test(make_test(0, -1, -1, 32767, 32767, 32767, -1, -1, 32767, 32767), 1'b0);

    // Circle against box: centre inside, exact touch on a face, far apart,
    // each contact side, both diagonal ties, zero radius and range corners.
    send_test(make_test(1, 0, 0, 0, 0, 16, 0, 0, 64, 64), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, 32, 0, 32, 64), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, 1000, 1000, 16, 16), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, 0, -100, 64, 32), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, 0, 20, 64, 64), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, -20, 0, 16, 64), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, 20, 0, 16, 64), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, 20, 20, 16, 16), 1'b0);
    send_test(make_test(1, 0, 0, 0, 0, 16, -20, -20, 16, 16), 1'b0);
    send_test(make_test(1, 5, 5, 0, 0, 0, 0, 0, 16, 16), 1'b0);
    send_test(make_test(1, 5, 5, 0, 0, 0, 10, 10, 16, 16), 1'b0);
    send_test(make_test(1, 68, 64, 0, 0, 20, 100, 100, 16, 16), 1'b0);
    send_test(make_test(1, -32768, -32768, 0, 0, 32767, 32767, 32767, 32767, 32767), 1'b0);
    send_test(make_test(1, 32767, 32767, 32767, 32767, 32767, -32768, -32768, 0, 0), 1'b0);
    send_test(make_test(1, -32768, 32767, 32767, 32767, 32767, 32767, -32768, 32767, 0),
              1'b0);

    // Let the pipeline empty completely once before the random part.
    wait_for_drain();

    // Random part: every fifty beats the sender may switch into a burst of
    // back-to-back beats; halfway through it waits for the pipeline to drain.
    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 200) wait_for_drain();
      send_test(random_test(), burst);
    end

    wait_for_drain();
    // Wait on past the pipeline depth, so a stray beat is caught.
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
